@@ design/tcw_pkg.sv @@
`default_nettype none
// ============================================================================
// tcw_pkg
// Shared types and constants of the text console writer: field widths,
// character codes, register indexes and the command and result records.
// ============================================================================
package tcw_pkg;

  localparam int CODE_W      = 8;
  localparam int INDEX_W     = 11;
  localparam int CELL_W      = 16;
  localparam int ATTR_W      = 8;
  localparam int TAB_W       = 4;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CODE_W-1:0] CODE_NUL     = 8'd0;
  localparam logic [CODE_W-1:0] CODE_TAB     = 8'd9;
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CODE_W-1:0] CODE_SPACE   = 8'd32;

  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ATTRIBUTE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAB_WIDTH      = 8'd1;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;
  localparam logic [TAB_W-1:0]  TAB_RESET  = 4'd4;

  typedef enum logic [2:0] {
    CMD_READ,
    CMD_PUT,
    CMD_TAB,
    CMD_NEWLINE,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CODE_W-1:0]  code;
    logic [INDEX_W-1:0] read_index;
  } cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0]  cell_value;
    logic [INDEX_W-1:0] cursor_position;
  } res_t;

  localparam int CMD_BITS = $bits(cmd_t);
  localparam int RES_BITS = $bits(res_t);

endpackage
`default_nettype wire

@@ design/tcw_fifo.sv @@
`default_nettype none
// ============================================================================
// tcw_fifo
// Small synchronous queue with full and empty flags.
// ============================================================================
module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ design/tcw_front.sv @@
`default_nettype none
// ============================================================================
// tcw_front
// Accepts input requests, sorts them into console commands and queues them
// for the back end.
// ============================================================================
module tcw_front
  import tcw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               mode,
  input  wire logic [CODE_W-1:0]  char_code,
  input  wire logic [INDEX_W-1:0] read_index,
  input  wire logic               clearing,
  input  wire logic               cmd_pop,
  output logic                    cmd_empty,
  output cmd_t                    cmd
);

  cmd_t                cmd_in;
  logic                q_full;
  logic [CMD_BITS-1:0] q_data;

  always_comb begin
    cmd_in.code       = char_code;
    cmd_in.read_index = read_index;
    priority if (mode) begin
      cmd_in.kind = CMD_READ;
    end else if (char_code == CODE_TAB) begin
      cmd_in.kind = CMD_TAB;
    end else if (char_code == CODE_NEWLINE) begin
      cmd_in.kind = CMD_NEWLINE;
    end else if (char_code == CODE_NUL) begin
      cmd_in.kind = CMD_NOP;
    end else begin
      cmd_in.kind = CMD_PUT;
    end
  end

  // no requests taken while the screen is being cleared after reset
  assign full = q_full || clearing;

  tcw_fifo #(
    .WIDTH(CMD_BITS),
    .DEPTH(2)
  ) u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .push   (push && !full),
    .wr_data(CMD_BITS'(cmd_in)),
    .full   (q_full),
    .pop    (cmd_pop),
    .rd_data(q_data),
    .empty  (cmd_empty)
  );

  assign cmd = cmd_t'(q_data);

endmodule
`default_nettype wire

@@ design/tcw_back.sv @@
`default_nettype none
// ============================================================================
// tcw_back
// Console engine: screen memory, cursor and scroll logic. The screen is a
// circular buffer of rows; a scroll moves the top row base and clears one row.
// ============================================================================
module tcw_back
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [ATTR_W-1:0] text_attribute,
  input  wire logic [TAB_W-1:0]  tab_width,
  input  wire logic              cmd_empty,
  input  wire cmd_t              cmd,
  output logic                   cmd_pop,
  input  wire logic              res_full,
  output logic                   res_push,
  output res_t                   res,
  output logic                   clearing
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int CW         = $clog2(CELL_COUNT);
  localparam int COLW       = $clog2(COLUMNS);

  localparam logic [CW-1:0]   LAST_CELL      = CW'(CELL_COUNT - 1);
  localparam logic [CW-1:0]   LAST_ROW_START = CW'(CELL_COUNT - COLUMNS);
  localparam logic [CW-1:0]   COLS_W         = CW'(COLUMNS);
  localparam logic [CW:0]     CELLS_X        = (CW + 1)'(CELL_COUNT);
  localparam logic [COLW-1:0] LAST_COL       = COLW'(COLUMNS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_READ_DATA,
    S_WRITE,
    S_SCROLL,
    S_RESULT
  } state_t;

  state_t            state;
  logic [CW-1:0]     cursor;
  logic [COLW-1:0]   col;
  logic [CW-1:0]     top_base;
  logic [CW-1:0]     clear_addr;
  logic [COLW-1:0]   scroll_cnt;
  logic [TAB_W-1:0]  rep;
  logic [CODE_W-1:0] code;
  logic [CW-1:0]     rd_log;
  logic              rd_in_range;
  logic [CELL_W-1:0] res_cell;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data;
  logic [CW-1:0]     rd_addr;
  logic              mem_we;
  logic [CW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CW-1:0]     cursor_phys;

  function automatic logic [CW-1:0] to_phys(input logic [CW-1:0] lg,
                                            input logic [CW-1:0] base);
    logic [CW:0] sum;
    sum = {1'b0, lg} + {1'b0, base};
    if (sum >= CELLS_X) begin
      sum = sum - CELLS_X;
    end
    return sum[CW-1:0];
  endfunction

  assign cursor_phys = to_phys(cursor, top_base);
  assign rd_addr     = to_phys(rd_log, top_base);
  assign clearing    = (state == S_CLEAR);
  assign cmd_pop     = (state == S_IDLE) && !cmd_empty;
  assign res_push    = (state == S_RESULT) && !res_full;

  assign res.cell_value      = res_cell;
  assign res.cursor_position = INDEX_W'(cursor);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clear_addr;
    mem_wdata = '0;
    unique case (state)
      S_CLEAR, S_SCROLL: begin
        mem_we = 1'b1;
      end
      S_WRITE: begin
        mem_we    = (rep != '0);
        mem_waddr = cursor_phys;
        mem_wdata = {text_attribute, code};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cursor     <= '0;
      col        <= '0;
      top_base   <= '0;
      clear_addr <= '0;
      scroll_cnt <= '0;
      rep        <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clear_addr == LAST_CELL) begin
            state <= S_IDLE;
          end else begin
            clear_addr <= clear_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (!cmd_empty) begin
            res_cell    <= '0;
            rd_log      <= CW'(cmd.read_index);
            rd_in_range <= (32'(cmd.read_index) < CELL_COUNT);
            code        <= cmd.code;
            rep         <= '0;
            unique case (cmd.kind)
              CMD_READ: begin
                state <= S_READ;
              end
              CMD_PUT: begin
                rep   <= TAB_W'(1);
                state <= S_WRITE;
              end
              CMD_TAB: begin
                rep   <= tab_width;
                code  <= CODE_SPACE;
                state <= S_WRITE;
              end
              CMD_NEWLINE: begin
                col <= '0;
                if (cursor >= LAST_ROW_START) begin
                  cursor     <= LAST_ROW_START;
                  clear_addr <= top_base;
                  scroll_cnt <= '0;
                  top_base   <= (top_base == LAST_ROW_START) ? '0 : top_base + COLS_W;
                  state      <= S_SCROLL;
                end else begin
                  cursor <= cursor + COLS_W - CW'(col);
                  state  <= S_RESULT;
                end
              end
              default: begin
                state <= S_RESULT;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_READ_DATA;
        end
        S_READ_DATA: begin
          res_cell <= rd_in_range ? rd_data : '0;
          state    <= S_RESULT;
        end
        S_WRITE: begin
          if (rep == '0) begin
            state <= S_RESULT;
          end else begin
            rep <= rep - 1'b1;
            if (cursor == LAST_CELL) begin
              cursor     <= LAST_ROW_START;
              col        <= '0;
              clear_addr <= top_base;
              scroll_cnt <= '0;
              top_base   <= (top_base == LAST_ROW_START) ? '0 : top_base + COLS_W;
              state      <= S_SCROLL;
            end else begin
              cursor <= cursor + 1'b1;
              col    <= (col == LAST_COL) ? '0 : col + 1'b1;
            end
          end
        end
        S_SCROLL: begin
          clear_addr <= clear_addr + 1'b1;
          scroll_cnt <= scroll_cnt + 1'b1;
          if (scroll_cnt == LAST_COL) begin
            state <= S_WRITE;
          end
        end
        S_RESULT: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= LAST_CELL && col <= LAST_COL)
    else $error("cursor out of screen");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    state == S_SCROLL |-> cursor == LAST_ROW_START && col == '0)
    else $error("cursor not on last row during scroll");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full && !cmd_pop)
    else $error("result pushed into full queue");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !cmd_pop && !res_push)
    else $error("request handled during clear pass");

endmodule
`default_nettype wire

@@ design/text_console_writer_unit.sv @@
`default_nettype none
// ============================================================================
// text_console_writer_unit
// Text-mode console: screen of attribute/character cells with a cursor.
// ============================================================================
// After reset the screen memory is cleared one cell per cycle, with full held
// high; configuration writes are taken throughout. Requests then go through a
// two-entry command queue into the engine, which handles one at a time against
// a screen memory with separate read and write ports: a NUL or a newline goes
// straight to its result, a printable character or a tab writes its cells, and
// a read fetches the addressed cell. A newline that scrolls, and a character or
// tab space that runs off the last cell, also clear one row of the screen.
// Results wait in a two-entry queue. Configuration writes are accepted every
// cycle and are meant to happen only while no request is in flight.
// ============================================================================
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic                   mode,
  input  wire logic [CODE_W-1:0]      char_code,
  input  wire logic [INDEX_W-1:0]     read_index,
  output logic                        empty,
  input  wire logic                   pop,
  output logic      [CELL_W-1:0]      cell_value,
  output logic      [INDEX_W-1:0]     cursor_position,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [ATTR_W-1:0]   text_attribute;
  logic [TAB_W-1:0]    tab_width;
  logic                clearing;
  logic                cmd_pop;
  logic                cmd_empty;
  cmd_t                cmd;
  logic                res_full;
  logic                res_push;
  res_t                res;
  logic [RES_BITS-1:0] res_q;
  res_t                res_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
      tab_width      <= TAB_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TEXT_ATTRIBUTE) begin
        text_attribute <= cfg_data[ATTR_W-1:0];
      end
      if (cfg_index == REG_TAB_WIDTH) begin
        tab_width <= cfg_data[TAB_W-1:0];
      end
    end
  end

  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .char_code (char_code),
    .read_index(read_index),
    .clearing  (clearing),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .text_attribute(text_attribute),
    .tab_width     (tab_width),
    .cmd_empty     (cmd_empty),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .res_full      (res_full),
    .res_push      (res_push),
    .res           (res),
    .clearing      (clearing)
  );

  tcw_fifo #(
    .WIDTH(RES_BITS),
    .DEPTH(2)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .push   (res_push),
    .wr_data(RES_BITS'(res)),
    .full   (res_full),
    .pop    (pop),
    .rd_data(res_q),
    .empty  (empty)
  );

  assign res_out         = res_t'(res_q);
  assign cell_value      = res_out.cell_value;
  assign cursor_position = res_out.cursor_position;

endmodule
`default_nettype wire

@@ bench/console_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// console_checker
// Watches the request, result and register channels of the text console
// writer. Keeps its own screen, cursor and register copies, works out the
// cell and cursor each accepted request should return, and compares every
// popped result with the oldest outstanding one. It reports the error count
// and the number of results still owed.
// ============================================================================
module console_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic                   full,
  input  logic                   mode,
  input  logic [CODE_W-1:0]      char_code,
  input  logic [INDEX_W-1:0]     read_index,
  input  logic                   empty,
  input  logic                   pop,
  input  logic [CELL_W-1:0]      cell_value,
  input  logic [INDEX_W-1:0]     cursor_position,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);

  localparam int CELLS = COLUMNS * ROWS;

  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cursor;
  logic [ATTR_W-1:0] attr;
  logic [TAB_W-1:0]  tab_count;
  res_t              owed_readouts [$];
  int                errors = 0;

  // cursor advance; running off the last cell scrolls up one row
  function automatic void step_cursor();
    int k;
    if (cursor + 1 >= CELLS) begin
      for (k = 0; k < CELLS - COLUMNS; k++) screen[k] = screen[k + COLUMNS];
      for (k = CELLS - COLUMNS; k < CELLS; k++) screen[k] = '0;
      cursor = CELLS - COLUMNS;
    end else begin
      cursor++;
    end
  endfunction

  function automatic void place_glyph(input logic [CODE_W-1:0] code);
    screen[cursor] = {attr, code};
    step_cursor();
  endfunction

  function automatic res_t run_console(input logic m, input logic [CODE_W-1:0] c,
                                       input logic [INDEX_W-1:0] ri);
    res_t r;
    int   k;
    r.cell_value = '0;
    if (m) begin
      if (ri < CELLS) r.cell_value = screen[ri];
    end else if (c == CODE_TAB) begin
      for (k = 0; k < tab_count; k++) place_glyph(CODE_SPACE);
    end else if (c == CODE_NEWLINE) begin
      cursor += (COLUMNS - 1) - (cursor % COLUMNS);
      step_cursor();
    end else if (c != CODE_NUL) begin
      place_glyph(c);
    end
    r.cursor_position = INDEX_W'(cursor);
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int k = 0; k < CELLS; k++) screen[k] = '0;
      cursor    = 0;
      attr      = ATTR_RESET;
      tab_count = TAB_RESET;
      owed_readouts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TEXT_ATTRIBUTE: attr = cfg_data[ATTR_W-1:0];
          REG_TAB_WIDTH:      tab_count = cfg_data[TAB_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) owed_readouts.push_back(run_console(mode, char_code, read_index));
      if (pop && !empty) begin
        if (owed_readouts.size() == 0) begin
          $error("unexpected result: cell_value %0h cursor_position %0d",
                 cell_value, cursor_position);
          errors++;
        end else begin
          want = owed_readouts.pop_front();
          if (cell_value !== want.cell_value) begin
            $error("cell_value: expected %0h, got %0h", want.cell_value, cell_value);
            errors++;
          end
          if (cursor_position !== want.cursor_position) begin
            $error("cursor_position: expected %0d, got %0d",
                   want.cursor_position, cursor_position);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= owed_readouts.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// Top of the text console writer bench. Writes the attribute and tab width
// registers before each phase, sends a short directed set of requests and then
// random console traffic (characters, newlines, tabs, NULs and cell reads)
// under varying sender and receiver idling, with one long receiver hold-off.
// The checker predicts and compares; this module only drives and decides.
// ============================================================================
module tb;
  import tcw_pkg::*;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int SETTLE      = 200;
  localparam int HOLD_CYCLES = 400;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   push;
  logic                   full;
  logic                   mode;
  logic [CODE_W-1:0]      char_code;
  logic [INDEX_W-1:0]     read_index;
  logic                   empty;
  logic                   pop;
  logic [CELL_W-1:0]      cell_value;
  logic [INDEX_W-1:0]     cursor_position;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int   fail_count;
  int   pending;
  int   send_idle = 0;
  int   recv_idle = 0;
  logic hold_go = 1'b0;
  logic hold_off = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  text_console_writer_unit #(.COLUMNS(COLUMNS), .ROWS(ROWS)) i_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .mode(mode), .char_code(char_code), .read_index(read_index),
    .empty(empty), .pop(pop),
    .cell_value(cell_value), .cursor_position(cursor_position),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) i_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .mode(mode), .char_code(char_code), .read_index(read_index),
    .empty(empty), .pop(pop),
    .cell_value(cell_value), .cursor_position(cursor_position),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else if (hold_off) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_idle);
  end

  // long receiver stall so the request side backs up
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [ATTR_W-1:0] a, input logic [TAB_W-1:0] t);
    write_reg(REG_TEXT_ATTRIBUTE, CFG_DATA_W'(a));
    write_reg(REG_TAB_WIDTH, CFG_DATA_W'(t));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(input logic m, input logic [CODE_W-1:0] c,
                              input logic [INDEX_W-1:0] ri);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    mode       <= m;
    char_code  <= c;
    read_index <= ri;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_random(output bit counted);
    int                 pick;
    logic [CODE_W-1:0]  c;
    logic [INDEX_W-1:0] ri;
    pick    = $urandom_range(99);
    c       = $urandom_range(255);
    ri      = $urandom_range(2047);
    counted = 1'b1;
    if (pick < 20) begin
      if (pick < 15) ri = $urandom_range(CELLS - 1);
      send_request(1'b1, c, ri);
    end else if (pick < 32) begin
      send_request(1'b0, CODE_NEWLINE, ri);
    end else if (pick < 38) begin
      send_request(1'b0, CODE_TAB, ri);
    end else begin
      if (pick < 41) c = CODE_NUL;
      counted = (c != CODE_NUL);
      send_request(1'b0, c, ri);
    end
  endtask

  task automatic run_traffic(input int count);
    int n;
    bit counted;
    n = 0;
    while (n < count) begin
      send_random(counted);
      if (counted) n++;
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    rst        = 1'b1;
    push       = 1'b0;
    mode       = 1'b0;
    char_code  = '0;
    read_index = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (7) @(posedge clk);
    rst       <= 1'b0;
    send_idle <= 15;
    recv_idle <= 66;
    configure(8'hFF, 4'd0);

    send_request(1'b1, 8'hFF, 11'd0);
    send_request(1'b0, CODE_NUL, 11'h7FF);
    send_request(1'b0, 8'hFF, 11'd0);
    send_request(1'b0, 8'h01, 11'd5);
    send_request(1'b0, 8'h80, 11'd0);
    send_request(1'b0, 8'h7F, 11'h400);
    send_request(1'b0, CODE_TAB, 11'd0);
    send_request(1'b0, CODE_NEWLINE, 11'd0);
    send_request(1'b0, 8'h41, 11'd0);
    send_request(1'b1, CODE_TAB, 11'd1);
    send_request(1'b1, CODE_NEWLINE, 11'd2);
    send_request(1'b1, 8'h55, 11'd3);
    send_request(1'b1, 8'hAA, 11'd80);
    send_request(1'b1, 8'h00, 11'd1999);
    send_request(1'b1, 8'h00, 11'd2000);
    send_request(1'b1, 8'hFF, 11'h7FF);
    run_traffic(300);
    drain();

    configure(8'h00, 4'd15);
    send_idle <= 66;
    recv_idle <= 15;
    hold_go   <= 1'b1;
    run_traffic(350);
    drain();

    configure(ATTR_W'($urandom_range(255)), TAB_W'($urandom_range(15)));
    send_idle <= 0;
    recv_idle <= 0;
    run_traffic(350);
    drain();

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
